// ----- rtl/priority_ready_and_blocked_queues_defines.svh -----
// Assertion macros for the priority ready and blocked queues block.
// Included by the top level, which carries the concurrent assertions; no other dependencies.
`ifndef PRIORITY_READY_AND_BLOCKED_QUEUES_DEFINES_SVH
`define PRIORITY_READY_AND_BLOCKED_QUEUES_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRBQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("prbq: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PRBQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("prbq: next-cycle check failed");

`endif

// ----- rtl/prbq_pkg.sv -----
// Shared constants for the priority ready and blocked queues block.
// Stands alone; used by the top level.
package prbq_pkg;

    localparam int DEF_NUM_TASKS     = 64;
    localparam int DEF_PRIORITY_BITS = 8;

    // Fixed port field widths.
    localparam int ID_W       = 6;
    localparam int PRIO_IN_W  = 8;
    localparam int COUNT_W    = 7;
    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 8;
    localparam int M_TDATA_W  = 32;

    localparam logic [1:0] OP_INS_READY   = 2'd0;
    localparam logic [1:0] OP_INS_BLOCKED = 2'd1;
    localparam logic [1:0] OP_REMOVE      = 2'd2;
    localparam logic [1:0] OP_FIND        = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_QUEUED = 2'd1;
    localparam logic [1:0] ST_ALREADY    = 2'd2;

endpackage

// ----- rtl/prbq_table.sv -----
// Task entry table: one write port, one registered read port, and a clearing
// sweep after reset. Stands alone; instantiated by the top level.
module prbq_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 24
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    output logic          clear_busy
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;
    logic          clr_busy_reg, clr_busy_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // The sweep clears the queued bit of every entry; the user side is idle meanwhile.
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clr_busy_reg;

endmodule

// ----- rtl/priority_ready_and_blocked_queues.sv -----
// Top level of the priority ready and blocked queues block.
// Depends on prbq_pkg, prbq_table and the assertion macro header.
//
// Two doubly linked task queues share one table of NUM_TASKS entries held in a
// single memory with a registered read. The ready queue is kept in ascending
// priority value, first in first out within a level; the blocked queue is first
// in first out. Each input beat carries one operation and yields exactly one
// result beat. After reset the table is swept clear before the first beat is
// taken. A find, a duplicate insert, a ready insert into an empty queue or an
// operation on a task that is not queued reads the entry once and then raises
// m_axis_tvalid; a blocked insert and a remove also patch the neighbor entries
// by read-modify-write through the one memory port. A ready insert into a
// non-empty queue walks the ordered list one entry per cycle on the read port,
// then patches the neighbors. A result held up by m_axis_tready adds its stall
// to the next one. The next beat is accepted once the result has moved into the
// output register.
`include "priority_ready_and_blocked_queues_defines.svh"

module priority_ready_and_blocked_queues #(
    parameter int NUM_TASKS     = prbq_pkg::DEF_NUM_TASKS,
    parameter int PRIORITY_BITS = prbq_pkg::DEF_PRIORITY_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // task_id [5:0], task_priority [13:6], zero [15:14]
    input  logic [prbq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // operation [1:0], zero [7:2]
    input  logic [prbq_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status [1:0], found_in_blocked [2], found_priority [10:3],
    // ready_count [17:11], blocked_count [24:18], ready_head_valid [25],
    // ready_head_id [31:26]
    output logic [prbq_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    import prbq_pkg::*;

    localparam int IW = $clog2(NUM_TASKS);
    localparam int LW = $clog2(NUM_TASKS + 1);
    localparam int PB = PRIORITY_BITS;
    localparam logic [LW-1:0] NULL_LINK = LW'(NUM_TASKS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_P_RD  = 3'd3;
    localparam logic [2:0] S_P_WR  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    typedef struct packed {
        logic          queued;
        logic          blocked;
        logic [PB-1:0] prio;
        logic [LW-1:0] nxt;
        logic [LW-1:0] prv;
    } entry_t;

    localparam int EW = $bits(entry_t);

    logic [2:0]    state_reg, state_next;
    logic [1:0]    op_reg, op_next;
    logic          id_ok_reg, id_ok_next;
    logic [IW-1:0] t_reg, t_next;
    logic [PB-1:0] prio_reg, prio_next;
    logic [1:0]    status_reg, status_next;
    logic          qflag_reg, qflag_next;
    logic [PB-1:0] fprio_reg, fprio_next;
    logic [LW-1:0] walk_reg, walk_next;
    logic [LW-1:0] cur_reg, cur_next;
    logic          pn_v_reg, pn_v_next;
    logic [LW-1:0] pn_addr_reg, pn_addr_next;
    logic [LW-1:0] pn_val_reg, pn_val_next;
    logic          pp_v_reg, pp_v_next;
    logic [LW-1:0] pp_addr_reg, pp_addr_next;
    logic [LW-1:0] pp_val_reg, pp_val_next;
    logic          psel_reg, psel_next;
    logic [LW-1:0] ready_first_reg, ready_first_next;
    logic [LW-1:0] blocked_first_reg, blocked_first_next;
    logic [LW-1:0] blocked_last_reg, blocked_last_next;
    logic [LW-1:0] ready_cnt_reg, ready_cnt_next;
    logic [LW-1:0] blocked_cnt_reg, blocked_cnt_next;
    logic          m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic          wr_en, rd_en, clear_busy;
    logic [IW-1:0] wr_addr, rd_addr;
    entry_t        wrec, rec;
    logic [EW-1:0] rd_data;

    logic          accept;
    logic [31:0]   id_w, prio_w;
    logic [LW-1:0] t_link;
    logic [31:0]   rc_w, bc_w, head_w, fp_w;

    prbq_table #(
        .DEPTH (NUM_TASKS),
        .AW    (IW),
        .DW    (EW)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wrec),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .clear_busy (clear_busy)
    );

    assign rec    = entry_t'(rd_data);
    assign id_w   = 32'(s_axis_tdata[ID_W-1:0]);
    assign prio_w = 32'(s_axis_tdata[ID_W+PRIO_IN_W-1:ID_W]);
    assign t_link = LW'(t_reg);

    assign s_axis_tready = (state_reg == S_IDLE) && !clear_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign rc_w   = 32'(ready_cnt_reg);
    assign bc_w   = 32'(blocked_cnt_reg);
    assign head_w = 32'(ready_first_reg);
    assign fp_w   = 32'(fprio_reg);

    always_comb begin
        state_next         = state_reg;
        op_next            = op_reg;
        id_ok_next         = id_ok_reg;
        t_next             = t_reg;
        prio_next          = prio_reg;
        status_next        = status_reg;
        qflag_next         = qflag_reg;
        fprio_next         = fprio_reg;
        walk_next          = walk_reg;
        cur_next           = cur_reg;
        pn_v_next          = pn_v_reg;
        pn_addr_next       = pn_addr_reg;
        pn_val_next        = pn_val_reg;
        pp_v_next          = pp_v_reg;
        pp_addr_next       = pp_addr_reg;
        pp_val_next        = pp_val_reg;
        psel_next          = psel_reg;
        ready_first_next   = ready_first_reg;
        blocked_first_next = blocked_first_reg;
        blocked_last_next  = blocked_last_reg;
        ready_cnt_next     = ready_cnt_reg;
        blocked_cnt_next   = blocked_cnt_reg;
        m_valid_next       = m_valid_reg;
        m_data_next        = m_data_reg;
        wr_en              = 1'b0;
        wr_addr            = '0;
        wrec               = '0;
        rd_en              = 1'b0;
        rd_addr            = '0;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next    = s_axis_tuser[1:0];
                    id_ok_next = (id_w < NUM_TASKS);
                    t_next     = id_w[IW-1:0];
                    prio_next  = prio_w[PB-1:0];
                    pn_v_next  = 1'b0;
                    pp_v_next  = 1'b0;
                    rd_en      = 1'b1;
                    rd_addr    = id_w[IW-1:0];
                    state_next = S_CHECK;
                end
            end

            S_CHECK: begin
                status_next = ST_OK;
                qflag_next  = 1'b0;
                fprio_next  = '0;
                state_next  = S_DONE;
                if (!id_ok_reg) begin
                    status_next = ST_NOT_QUEUED;
                end else if (op_reg == OP_INS_READY || op_reg == OP_INS_BLOCKED) begin
                    if (rec.queued) begin
                        status_next = ST_ALREADY;
                        qflag_next  = rec.blocked;
                        fprio_next  = rec.prio;
                    end else if (op_reg == OP_INS_READY) begin
                        fprio_next = prio_reg;
                        if (ready_first_reg == NULL_LINK) begin
                            wr_en            = 1'b1;
                            wr_addr          = t_reg;
                            wrec             = '{queued: 1'b1, blocked: 1'b0, prio: prio_reg,
                                                 nxt: NULL_LINK, prv: NULL_LINK};
                            ready_first_next = t_link;
                            ready_cnt_next   = ready_cnt_reg + LW'(1);
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = ready_first_reg[IW-1:0];
                            walk_next  = ready_first_reg;
                            cur_next   = NULL_LINK;
                            state_next = S_WALK;
                        end
                    end else begin
                        qflag_next = 1'b1;
                        wr_en      = 1'b1;
                        wr_addr    = t_reg;
                        wrec       = '{queued: 1'b1, blocked: 1'b1, prio: '0,
                                       nxt: NULL_LINK, prv: blocked_last_reg};
                        if (blocked_last_reg != NULL_LINK) begin
                            pn_v_next    = 1'b1;
                            pn_addr_next = blocked_last_reg;
                            pn_val_next  = t_link;
                        end else begin
                            blocked_first_next = t_link;
                        end
                        blocked_last_next = t_link;
                        blocked_cnt_next  = blocked_cnt_reg + LW'(1);
                        state_next        = S_P_RD;
                    end
                end else if (!rec.queued) begin
                    status_next = ST_NOT_QUEUED;
                end else begin
                    qflag_next = rec.blocked;
                    fprio_next = rec.prio;
                    if (op_reg == OP_REMOVE) begin
                        wr_en        = 1'b1;
                        wr_addr      = t_reg;
                        wrec         = rec;
                        wrec.queued  = 1'b0;
                        if (rec.prv != NULL_LINK) begin
                            pn_v_next    = 1'b1;
                            pn_addr_next = rec.prv;
                            pn_val_next  = rec.nxt;
                        end else if (rec.blocked) begin
                            blocked_first_next = rec.nxt;
                        end else begin
                            ready_first_next = rec.nxt;
                        end
                        if (rec.nxt != NULL_LINK) begin
                            pp_v_next    = 1'b1;
                            pp_addr_next = rec.nxt;
                            pp_val_next  = rec.prv;
                        end else if (rec.blocked) begin
                            blocked_last_next = rec.prv;
                        end
                        if (rec.blocked) begin
                            if (blocked_cnt_reg != '0) begin
                                blocked_cnt_next = blocked_cnt_reg - LW'(1);
                            end
                        end else if (ready_cnt_reg != '0) begin
                            ready_cnt_next = ready_cnt_reg - LW'(1);
                        end
                        state_next = S_P_RD;
                    end
                end
            end

            // The entry read here sits right after cur; a null cur means the list head.
            S_WALK: begin
                if (rec.prio > prio_reg) begin
                    wr_en        = 1'b1;
                    wr_addr      = t_reg;
                    wrec         = '{queued: 1'b1, blocked: 1'b0, prio: prio_reg,
                                     nxt: walk_reg, prv: cur_reg};
                    pp_v_next    = 1'b1;
                    pp_addr_next = walk_reg;
                    pp_val_next  = t_link;
                    if (cur_reg == NULL_LINK) begin
                        ready_first_next = t_link;
                    end else begin
                        pn_v_next    = 1'b1;
                        pn_addr_next = cur_reg;
                        pn_val_next  = t_link;
                    end
                    ready_cnt_next = ready_cnt_reg + LW'(1);
                    state_next     = S_P_RD;
                end else if (rec.nxt == NULL_LINK) begin
                    wr_en          = 1'b1;
                    wr_addr        = t_reg;
                    wrec           = '{queued: 1'b1, blocked: 1'b0, prio: prio_reg,
                                       nxt: NULL_LINK, prv: walk_reg};
                    pn_v_next      = 1'b1;
                    pn_addr_next   = walk_reg;
                    pn_val_next    = t_link;
                    ready_cnt_next = ready_cnt_reg + LW'(1);
                    state_next     = S_P_RD;
                end else begin
                    cur_next  = walk_reg;
                    walk_next = rec.nxt;
                    rd_en     = 1'b1;
                    rd_addr   = rec.nxt[IW-1:0];
                end
            end

            // Neighbor link repairs: the next-link patch first, then the prev-link patch.
            S_P_RD: begin
                if (pn_v_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = pn_addr_reg[IW-1:0];
                    psel_next  = 1'b0;
                    state_next = S_P_WR;
                end else if (pp_v_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = pp_addr_reg[IW-1:0];
                    psel_next  = 1'b1;
                    state_next = S_P_WR;
                end else begin
                    state_next = S_DONE;
                end
            end

            S_P_WR: begin
                wr_en = 1'b1;
                wrec  = rec;
                if (!psel_reg) begin
                    wr_addr   = pn_addr_reg[IW-1:0];
                    wrec.nxt  = pn_val_reg;
                    pn_v_next = 1'b0;
                end else begin
                    wr_addr   = pp_addr_reg[IW-1:0];
                    wrec.prv  = pp_val_reg;
                    pp_v_next = 1'b0;
                end
                state_next = S_P_RD;
            end

            S_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next[1:0]   = status_reg;
                    m_data_next[2]     = qflag_reg;
                    m_data_next[10:3]  = fp_w[7:0];
                    m_data_next[17:11] = rc_w[COUNT_W-1:0];
                    m_data_next[24:18] = bc_w[COUNT_W-1:0];
                    if (ready_first_reg != NULL_LINK) begin
                        m_data_next[25]    = 1'b1;
                        m_data_next[31:26] = head_w[ID_W-1:0];
                    end
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            pn_v_reg          <= 1'b0;
            pp_v_reg          <= 1'b0;
            ready_first_reg   <= NULL_LINK;
            blocked_first_reg <= NULL_LINK;
            blocked_last_reg  <= NULL_LINK;
            ready_cnt_reg     <= '0;
            blocked_cnt_reg   <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            pn_v_reg          <= pn_v_next;
            pp_v_reg          <= pp_v_next;
            ready_first_reg   <= ready_first_next;
            blocked_first_reg <= blocked_first_next;
            blocked_last_reg  <= blocked_last_next;
            ready_cnt_reg     <= ready_cnt_next;
            blocked_cnt_reg   <= blocked_cnt_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        id_ok_reg   <= id_ok_next;
        t_reg       <= t_next;
        prio_reg    <= prio_next;
        status_reg  <= status_next;
        qflag_reg   <= qflag_next;
        fprio_reg   <= fprio_next;
        walk_reg    <= walk_next;
        cur_reg     <= cur_next;
        pn_addr_reg <= pn_addr_next;
        pn_val_reg  <= pn_val_next;
        pp_addr_reg <= pp_addr_next;
        pp_val_reg  <= pp_val_next;
        psel_reg    <= psel_next;
        m_data_reg  <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    `PRBQ_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, (rc_w + bc_w) <= NUM_TASKS)
    `PRBQ_ASSERT_IMP(a_ready_empty, aclk, aresetn, 1'b1, (ready_first_reg == NULL_LINK) == (ready_cnt_reg == '0))
    `PRBQ_ASSERT_IMP(a_blocked_ends, aclk, aresetn, 1'b1, (blocked_first_reg == NULL_LINK) == (blocked_last_reg == NULL_LINK))
    `PRBQ_ASSERT_IMP(a_no_rw_clash, aclk, aresetn, rd_en && wr_en, rd_addr != wr_addr)
    `PRBQ_ASSERT_NXT(a_accept_check, aclk, aresetn, accept, state_reg == S_CHECK)

endmodule

// ----- sim/priority_ready_and_blocked_queues_tb.sv -----
`timescale 1ns / 1ps
// Testbench for priority_ready_and_blocked_queues: directed table, then random phases
// that fill and drain both task queues, checked against a local queue predictor or,
// for the typed directed rows, fixed expected results. Depends on prbq_pkg and the block's RTL only.
module priority_ready_and_blocked_queues_tb;
    import prbq_pkg::*;

    localparam int          TASKS       = DEF_NUM_TASKS;
    localparam logic [6:0]  NO_LINK     = 7'd64;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          HOLD_AT     = 300;
    localparam int          HOLD_CYCLES = 600;

    // Result beat as packed on m_axis_tdata, highest field first.
    typedef struct packed {
        logic [5:0] head_id;
        logic       head_valid;
        logic [6:0] blk_n;
        logic [6:0] rdy_n;
        logic [7:0] prio;
        logic       in_blocked;
        logic [1:0] status;
    } outcome_t;

    typedef struct {
        logic [1:0] op;
        logic [5:0] id;
        logic [7:0] prio;
        bit         typed;
        outcome_t   want;
    } row_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // Predictor copy of the task table and queue heads.
    logic       on_q   [TASKS];
    logic       in_blk [TASKS];
    logic [7:0] pri    [TASKS];
    logic [6:0] nxt    [TASKS];
    logic [6:0] prv    [TASKS];
    logic [6:0] rq_head, bq_head, bq_tail;
    logic [6:0] rq_count, bq_count;

    outcome_t pending_results[$];
    row_t     directed_rows[$];
    int       error_count  = 0;
    int       results_seen = 0;
    int       cycle_count  = 0;
    int       burst_left   = 0;
    bit       gaps_on      = 1'b1;

    priority_ready_and_blocked_queues u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("priority_ready_and_blocked_queues_tb: done, errors");
            $finish;
        end
    end

    function automatic outcome_t mk_outcome(logic [1:0] status, logic in_blocked,
                                            logic [7:0] prio, logic [6:0] rdy_n,
                                            logic [6:0] blk_n, logic head_valid,
                                            logic [5:0] head_id);
        outcome_t o;
        o.status     = status;
        o.in_blocked = in_blocked;
        o.prio       = prio;
        o.rdy_n      = rdy_n;
        o.blk_n      = blk_n;
        o.head_valid = head_valid;
        o.head_id    = head_id;
        return o;
    endfunction

    // Applies one operation to the predictor's queues and returns the result beat.
    function automatic outcome_t predict_queue_op(logic [1:0] op, logic [5:0] id,
                                                  logic [7:0] prio);
        outcome_t r;
        logic [6:0] cur, nx, pv;
        bit stop;
        r = '0;
        if (op == OP_INS_READY || op == OP_INS_BLOCKED) begin
            if (on_q[id]) begin
                r.status     = ST_ALREADY;
                r.in_blocked = in_blk[id];
                r.prio       = pri[id];
            end else if (op == OP_INS_READY) begin
                pri[id]    = prio;
                in_blk[id] = 1'b0;
                on_q[id]   = 1'b1;
                if (rq_head == NO_LINK) begin
                    rq_head = {1'b0, id};
                    nxt[id] = NO_LINK;
                    prv[id] = NO_LINK;
                end else if (prio < pri[rq_head[5:0]]) begin
                    nxt[id] = rq_head;
                    prv[id] = NO_LINK;
                    prv[rq_head[5:0]] = {1'b0, id};
                    rq_head = {1'b0, id};
                end else begin
                    // Walk past every entry of equal or lower priority value.
                    cur  = rq_head;
                    stop = 1'b0;
                    while (!stop) begin
                        nx = nxt[cur[5:0]];
                        if (nx == NO_LINK || pri[nx[5:0]] > prio) stop = 1'b1;
                        else cur = nx;
                    end
                    nxt[id] = nxt[cur[5:0]];
                    prv[id] = cur;
                    if (nxt[cur[5:0]] != NO_LINK) prv[nxt[cur[5:0]][5:0]] = {1'b0, id};
                    nxt[cur[5:0]] = {1'b0, id};
                end
                rq_count++;
                r.prio = prio;
            end else begin
                pri[id]    = 8'd0;
                in_blk[id] = 1'b1;
                on_q[id]   = 1'b1;
                nxt[id]    = NO_LINK;
                prv[id]    = bq_tail;
                if (bq_tail != NO_LINK) nxt[bq_tail[5:0]] = {1'b0, id};
                else bq_head = {1'b0, id};
                bq_tail = {1'b0, id};
                bq_count++;
                r.in_blocked = 1'b1;
            end
        end else if (!on_q[id]) begin
            r.status = ST_NOT_QUEUED;
        end else begin
            r.in_blocked = in_blk[id];
            r.prio       = pri[id];
            if (op == OP_REMOVE) begin
                pv = prv[id];
                nx = nxt[id];
                if (pv != NO_LINK) nxt[pv[5:0]] = nx;
                else if (in_blk[id]) bq_head = nx;
                else rq_head = nx;
                if (nx != NO_LINK) prv[nx[5:0]] = pv;
                else if (in_blk[id]) bq_tail = pv;
                if (in_blk[id]) begin
                    if (bq_count > 0) bq_count--;
                end else begin
                    if (rq_count > 0) rq_count--;
                end
                on_q[id] = 1'b0;
            end
        end
        r.rdy_n      = rq_count;
        r.blk_n      = bq_count;
        r.head_valid = (rq_head != NO_LINK);
        r.head_id    = r.head_valid ? rq_head[5:0] : 6'd0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
    endtask

    task automatic add_row(logic [1:0] op, logic [5:0] id, logic [7:0] prio,
                           bit typed, outcome_t want);
        row_t r;
        r.op    = op;
        r.id    = id;
        r.prio  = prio;
        r.typed = typed;
        r.want  = want;
        directed_rows.push_back(r);
    endtask

    // Offers one beat, waits for the accept, records the expected result and
    // then, at the end of a burst, idles for a random gap when gaps are on.
    task automatic offer_beat(logic [1:0] op, logic [5:0] id, logic [7:0] prio,
                              bit typed, outcome_t want);
        outcome_t predicted;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, prio, id};
        s_axis_tuser  <= {6'd0, op};
        do @(posedge aclk); while (!s_axis_tready);
        predicted = predict_queue_op(op, id, prio);
        pending_results.push_back(typed ? want : predicted);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = gaps_on ? $urandom_range(1, 8) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    always @(posedge aclk) begin : check_results
        outcome_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = outcome_t'(m_axis_tdata);
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat", m_axis_tdata, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.in_blocked !== want.in_blocked)
                    report_mismatch("found_in_blocked", 32'(got.in_blocked),
                                    32'(want.in_blocked));
                if (got.prio !== want.prio)
                    report_mismatch("found_priority", 32'(got.prio), 32'(want.prio));
                if (got.rdy_n !== want.rdy_n)
                    report_mismatch("ready_count", 32'(got.rdy_n), 32'(want.rdy_n));
                if (got.blk_n !== want.blk_n)
                    report_mismatch("blocked_count", 32'(got.blk_n), 32'(want.blk_n));
                if (got.head_valid !== want.head_valid)
                    report_mismatch("ready_head_valid", 32'(got.head_valid),
                                    32'(want.head_valid));
                if (got.head_id !== want.head_id)
                    report_mismatch("ready_head_id", 32'(got.head_id), 32'(want.head_id));
            end
            results_seen++;
        end
    end

    // Result side: stall patterns that change every so often, plus one long
    // hold-off so that the block backs up and stops taking input.
    initial begin : result_sink
        int mode, span, tick;
        bit held;
        held = 1'b0;
        tick = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge aclk);
                tick++;
                if (!held && results_seen >= HOLD_AT) begin
                    held = 1'b1;
                    m_axis_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 99) < 60);
                    2: m_axis_tready <= (tick % 4 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 15) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int r, style;
        bit fill, want_queued;
        logic [1:0] op;
        logic [5:0] id;
        logic [7:0] prio;
        logic [5:0] cands[$];

        for (int i = 0; i < TASKS; i++) begin
            on_q[i]   = 1'b0;
            in_blk[i] = 1'b0;
            pri[i]    = 8'd0;
            nxt[i]    = 7'd0;
            prv[i]    = 7'd0;
        end
        rq_head  = NO_LINK;
        bq_head  = NO_LINK;
        bq_tail  = NO_LINK;
        rq_count = 7'd0;
        bq_count = 7'd0;

        add_row(OP_FIND,        6'd0,  8'd0,   1'b1,
                mk_outcome(ST_NOT_QUEUED, 1'b0, 8'd0, 7'd0, 7'd0, 1'b0, 6'd0));
        add_row(OP_REMOVE,      6'd63, 8'd0,   1'b1,
                mk_outcome(ST_NOT_QUEUED, 1'b0, 8'd0, 7'd0, 7'd0, 1'b0, 6'd0));
        add_row(OP_INS_READY,   6'd0,  8'd255, 1'b1,
                mk_outcome(ST_OK, 1'b0, 8'd255, 7'd1, 7'd0, 1'b1, 6'd0));
        add_row(OP_INS_READY,   6'd63, 8'd0,   1'b1,
                mk_outcome(ST_OK, 1'b0, 8'd0, 7'd2, 7'd0, 1'b1, 6'd63));
        add_row(OP_INS_READY,   6'd0,  8'd5,   1'b1,
                mk_outcome(ST_ALREADY, 1'b0, 8'd255, 7'd2, 7'd0, 1'b1, 6'd63));
        // Blocked inserts ignore the priority field.
        add_row(OP_INS_BLOCKED, 6'd10, 8'hAA, 1'b0, '0);
        add_row(OP_INS_BLOCKED, 6'd11, 8'h55, 1'b0, '0);
        add_row(OP_INS_BLOCKED, 6'd10, 8'd3,  1'b0, '0);
        add_row(OP_INS_READY,   6'd10, 8'd7,  1'b0, '0);
        // Ties go behind the tail and behind the head, then one in the middle.
        add_row(OP_INS_READY,   6'd20, 8'd255, 1'b0, '0);
        add_row(OP_INS_READY,   6'd21, 8'd0,   1'b0, '0);
        add_row(OP_INS_READY,   6'd22, 8'd128, 1'b0, '0);
        add_row(OP_FIND,        6'd22, 8'd0,   1'b0, '0);
        add_row(OP_FIND,        6'd11, 8'd0,   1'b0, '0);
        add_row(OP_REMOVE,      6'd63, 8'd0,   1'b0, '0);
        add_row(OP_REMOVE,      6'd20, 8'd0,   1'b0, '0);
        add_row(OP_REMOVE,      6'd22, 8'd0,   1'b0, '0);
        add_row(OP_REMOVE,      6'd10, 8'd0,   1'b0, '0);
        add_row(OP_INS_BLOCKED, 6'd12, 8'd0,   1'b0, '0);
        add_row(OP_REMOVE,      6'd12, 8'd0,   1'b0, '0);
        add_row(OP_REMOVE,      6'd11, 8'd0,   1'b0, '0);
        add_row(OP_REMOVE,      6'd11, 8'd0,   1'b0, '0);
        add_row(OP_FIND,        6'd10, 8'd0,   1'b0, '0);
        add_row(OP_REMOVE,      6'd21, 8'd0,   1'b0, '0);
        add_row(OP_REMOVE,      6'd0,  8'd0,   1'b0, '0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            offer_beat(directed_rows[i].op, directed_rows[i].id, directed_rows[i].prio,
                       directed_rows[i].typed, directed_rows[i].want);

        // Two filling phases out of every three, so the ready list grows long
        // enough for full-length walks before it is drained again.
        for (int phase = 0; phase < 12; phase++) begin
            fill    = (phase % 3) != 2;
            style   = $urandom_range(0, 3);
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < 100; k++) begin
                r = $urandom_range(0, 99);
                if (fill)
                    op = (r < 45) ? OP_INS_READY : (r < 65) ? OP_INS_BLOCKED :
                         (r < 85) ? OP_REMOVE : OP_FIND;
                else
                    op = (r < 15) ? OP_INS_READY : (r < 25) ? OP_INS_BLOCKED :
                         (r < 80) ? OP_REMOVE : OP_FIND;
                want_queued = (op == OP_REMOVE || op == OP_FIND);
                cands.delete();
                for (int i = 0; i < TASKS; i++)
                    if (on_q[i] == want_queued) cands.push_back(6'(i));
                if (cands.size() > 0 && $urandom_range(0, 99) < 80)
                    id = cands[$urandom_range(0, cands.size() - 1)];
                else
                    id = 6'($urandom_range(0, TASKS - 1));
                case (style)
                    0: prio = 8'($urandom_range(0, 255));
                    1: prio = 8'($urandom_range(0, 3));
                    2: prio = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    default: prio = 8'($urandom_range(248, 255));
                endcase
                offer_beat(op, id, prio, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (error_count == 0) begin
            $display("priority_ready_and_blocked_queues_tb: done, clean");
        end else begin
            $display("priority_ready_and_blocked_queues_tb: done, errors");
        end
        $finish;
    end

endmodule
